// ----- sv/lfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and constants for the cell chain and the top level.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int CAP_RESET       = 16;
    localparam int KEY_W           = 32;
    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 32;
    localparam int CFG_W           = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE   = 3'b001,
        OP_MOVE   = 3'b010,
        OP_INSERT = 3'b100
    } t_op;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        t_entry ent;
        logic   le;
    } t_link;

    typedef struct packed {
        logic               capture;
        logic [KEY_W-1:0]   match_key;
        t_op                op;
        logic [COUNT_W-1:0] thr;
        t_entry             new_ent;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ----- sv/lfu_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lfu_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;

    modport source(output valid, command, lookup_key, write_value, input ready);
    modport sink(input valid, command, lookup_key, write_value, output ready);
endinterface

interface lfu_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] read_value;

    modport source(output valid, found, read_value, input ready);
    modport sink(input valid, found, read_value, output ready);
endinterface
`default_nettype wire

// ----- sv/lfu_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache cell
// Holds one entry of the eviction-ordered chain and shifts with its neighbors.
// ----------------------------------------------------------------------------
module lfu_cell #(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire lfu_pkg::t_cell_ctrl i_ctrl,
    input  wire  [IW-1:0]       i_hit_idx,
    input  wire lfu_pkg::t_link i_prev,
    input  wire lfu_pkg::t_link i_next,
    output lfu_pkg::t_link      o_link,
    output logic                o_hit
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    lfu_pkg::t_entry r_ent;
    lfu_pkg::t_entry n_ent;
    logic            r_hit;
    logic            w_is_h;
    logic            w_le;

    always_comb begin
        w_is_h = (i_ctrl.op == lfu_pkg::OP_MOVE) && (i_hit_idx == MY_IDX);
        w_le   = r_ent.valid && ((r_ent.count <= i_ctrl.thr) || w_is_h);
    end

    always_comb begin
        n_ent = r_ent;
        unique case (i_ctrl.op)
            lfu_pkg::OP_MOVE: begin
                if (MY_IDX >= i_hit_idx) begin
                    if (i_next.le) begin
                        n_ent = i_next.ent;
                    end else if (w_le) begin
                        n_ent = i_ctrl.new_ent;
                    end
                end
            end
            lfu_pkg::OP_INSERT: begin
                if (!w_le) begin
                    if (i_prev.le) begin
                        n_ent = i_ctrl.new_ent;
                    end else if (i_prev.ent.valid) begin
                        n_ent = i_prev.ent;
                    end
                end
            end
            lfu_pkg::OP_NONE: begin
                n_ent = r_ent;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_ent <= n_ent;
            if (i_ctrl.capture) begin
                r_hit <= r_ent.valid && (r_ent.key == i_ctrl.match_key);
            end
        end
    end

    assign o_link.ent = r_ent;
    assign o_link.le  = w_le;
    assign o_hit      = r_hit;

endmodule
`default_nettype wire

// ----- sv/lfu_cache_with_lru_tiebreak.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Fully associative key/value cache built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Each transaction passes through S_IDLE, S_SEL and S_UPD: the accept cycle
// compares the key in every cell at once, S_SEL then selects the hit entry
// and forms its new count, and S_UPD shifts the cell chain by one place so
// that the entries stay ordered by use count and, among equal counts, by
// age. The victim is therefore always the first cell, and no age stamps are
// stored. A response that is not taken holds the update state until the
// response register frees. Reset needs no clearing pass. Capacity writes are
// taken only while the cache is empty.
module lfu_cache_with_lru_tiebreak #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    lfu_req_if.sink                   i_req,
    lfu_rsp_if.source                 o_rsp,
    input  wire                       i_cfg_we,
    input  wire  [lfu_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > lfu_pkg::CFG_W) ? OW : lfu_pkg::CFG_W;
    localparam logic [CW-1:0] ENT_C   = CW'(ENTRIES);
    localparam logic [OW-1:0] CAP_RST = (lfu_pkg::CAP_RESET > ENTRIES) ?
                                        OW'(ENTRIES) : OW'(lfu_pkg::CAP_RESET);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEL  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                       r_state;
    logic [OW-1:0]                r_occ;
    logic [OW-1:0]                r_cap;
    logic                         r_cmd;
    logic [lfu_pkg::KEY_W-1:0]    r_key;
    logic [lfu_pkg::DATA_W-1:0]   r_val;
    lfu_pkg::t_op                 r_op;
    logic [IW-1:0]                r_idx;
    logic [lfu_pkg::COUNT_W-1:0]  r_thr;
    logic [lfu_pkg::DATA_W-1:0]   r_new_data;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [lfu_pkg::DATA_W-1:0]   r_out_data;
    logic                         r_res_found;
    logic [lfu_pkg::DATA_W-1:0]   r_res_data;
    logic                         r_inc_occ;

    lfu_pkg::t_cell_ctrl          w_ctrl;
    lfu_pkg::t_link               w_link [ENTRIES];
    logic [ENTRIES-1:0]           w_hit;
    logic [ENTRIES-1:0]           w_valid;
    logic                         w_accept;
    logic                         w_go;
    logic                         w_any;
    logic [IW-1:0]                w_idx;
    logic [lfu_pkg::COUNT_W-1:0]  w_hcount;
    logic [lfu_pkg::DATA_W-1:0]   w_hdata;
    logic [CW-1:0]                w_cfg_ext;
    logic [OW-1:0]                w_cfg_cap;
    lfu_pkg::t_link               w_head;
    lfu_pkg::t_link               w_tail;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_go        = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.read_value = r_out_data;

    always_comb begin
        w_head     = '0;
        w_head.le  = 1'b1;
        w_tail     = '0;
        w_tail.le  = 1'b0;
    end

    always_comb begin
        w_ctrl.capture           = w_accept;
        w_ctrl.match_key         = i_req.lookup_key;
        w_ctrl.op                = w_go ? r_op : lfu_pkg::OP_NONE;
        w_ctrl.thr               = r_thr;
        w_ctrl.new_ent.valid     = 1'b1;
        w_ctrl.new_ent.key       = r_key;
        w_ctrl.new_ent.data      = r_new_data;
        w_ctrl.new_ent.count     = r_thr;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0 && ENTRIES == 1) begin : g_only
            lfu_cell #(.IW(IW), .IDX(g)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .i_hit_idx(r_idx),
                .i_prev(w_head), .i_next(w_tail), .o_link(w_link[g]), .o_hit(w_hit[g])
            );
        end else if (g == 0) begin : g_first
            lfu_cell #(.IW(IW), .IDX(g)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .i_hit_idx(r_idx),
                .i_prev(w_head), .i_next(w_link[g+1]), .o_link(w_link[g]),
                .o_hit(w_hit[g])
            );
        end else if (g == ENTRIES - 1) begin : g_last
            lfu_cell #(.IW(IW), .IDX(g)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .i_hit_idx(r_idx),
                .i_prev(w_link[g-1]), .i_next(w_tail), .o_link(w_link[g]),
                .o_hit(w_hit[g])
            );
        end else begin : g_mid
            lfu_cell #(.IW(IW), .IDX(g)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .i_hit_idx(r_idx),
                .i_prev(w_link[g-1]), .i_next(w_link[g+1]), .o_link(w_link[g]),
                .o_hit(w_hit[g])
            );
        end
        assign w_valid[g] = w_link[g].ent.valid;
    end

    always_comb begin
        w_any    = |w_hit;
        w_idx    = '0;
        w_hcount = '0;
        w_hdata  = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            w_idx    = w_idx | (IW'(j) & {IW{w_hit[j]}});
            w_hcount = w_hcount | (w_link[j].ent.count & {lfu_pkg::COUNT_W{w_hit[j]}});
            w_hdata  = w_hdata | (w_link[j].ent.data & {lfu_pkg::DATA_W{w_hit[j]}});
        end
    end

    always_comb begin
        w_cfg_ext = CW'(i_cfg_wdata);
        if (w_cfg_ext == '0) begin
            w_cfg_cap = OW'(1);
        end else if (w_cfg_ext > ENT_C) begin
            w_cfg_cap = OW'(ENTRIES);
        end else begin
            w_cfg_cap = OW'(w_cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cap       <= CAP_RST;
            r_out_valid <= 1'b0;
            r_op        <= lfu_pkg::OP_NONE;
            r_inc_occ   <= 1'b0;
        end else begin
            if (i_cfg_we && (r_occ == '0)) begin
                r_cap <= w_cfg_cap;
            end
            if (o_rsp.ready && !w_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_req.command;
                        r_key   <= i_req.lookup_key;
                        r_val   <= i_req.write_value;
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (w_any) begin
                        r_op        <= lfu_pkg::OP_MOVE;
                        r_inc_occ   <= 1'b0;
                        r_idx       <= w_idx;
                        r_thr       <= (w_hcount == lfu_pkg::COUNT_MAX) ?
                                       lfu_pkg::COUNT_MAX : w_hcount + lfu_pkg::COUNT_ONE;
                        r_new_data  <= (r_cmd == lfu_pkg::CMD_PUT) ? r_val : w_hdata;
                        r_res_found <= 1'b1;
                        r_res_data  <= (r_cmd == lfu_pkg::CMD_PUT) ? '0 : w_hdata;
                    end else if (r_cmd == lfu_pkg::CMD_PUT) begin
                        r_idx       <= '0;
                        r_thr       <= lfu_pkg::COUNT_ONE;
                        r_new_data  <= r_val;
                        r_res_found <= 1'b0;
                        r_res_data  <= '0;
                        if (r_occ >= r_cap) begin
                            r_op      <= lfu_pkg::OP_MOVE;
                            r_inc_occ <= 1'b0;
                        end else begin
                            r_op      <= lfu_pkg::OP_INSERT;
                            r_inc_occ <= 1'b1;
                        end
                    end else begin
                        r_op        <= lfu_pkg::OP_NONE;
                        r_inc_occ   <= 1'b0;
                        r_idx       <= '0;
                        r_thr       <= lfu_pkg::COUNT_ONE;
                        r_new_data  <= '0;
                        r_res_found <= 1'b0;
                        r_res_data  <= '0;
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_go) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_data  <= r_res_data;
                        if (r_inc_occ) begin
                            r_occ <= r_occ + OW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_occ_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= r_cap)
        else $error("occupancy above capacity");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_occ))
        else $error("valid cells do not match occupancy");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> $onehot0(w_hit))
        else $error("key present in more than one cell");

    a_rsp_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("response raised outside the update cycle");

endmodule
`default_nettype wire
